@@ sv/wvad_pkg.sv @@
// Shared types and constants for the windowed velocity average and distance block.
package wvad_pkg;

	localparam int VEL_W     = 16;
	localparam int POS_W     = 16;
	localparam int DIFF_W    = 17;
	localparam int DIST_W    = 17;
	localparam int WLEN_W    = 7;
	localparam int SQ_W      = 36;
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 56;

	localparam logic [WLEN_W-1:0] WLEN_RST = 7'd8;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

@@ sv/wvad_win_mem.sv @@
// Velocity window store: one write port, one registered read port.
module wvad_win_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/wvad_divsqrt.sv @@
// Shared shift-and-subtract unit: restoring division or digit-by-digit square root.
module wvad_divsqrt #(
	parameter int DIV_W = 23,
	parameter int DVS_W = 7,
	localparam int OP_W = (DIV_W > wvad_pkg::SQ_W) ? DIV_W : wvad_pkg::SQ_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wvad_pkg::unit_ctl_t   ctl,
	input  logic [OP_W-1:0]       opnd,
	input  logic [DVS_W-1:0]      divisor,
	output wvad_pkg::unit_sts_t   sts,
	output logic [OP_W-1:0]       res
);

	localparam int RW_SQ = wvad_pkg::SQ_W / 2 + 3;
	localparam int RW    = (RW_SQ > DVS_W + 1) ? RW_SQ : DVS_W + 1;
	localparam int SC_W  = $clog2(OP_W + 1);

	logic [OP_W-1:0]  op_q;
	logic [OP_W-1:0]  res_q;
	logic [RW-1:0]    rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [SC_W-1:0]  steps_q;
	logic             mode_q;
	logic             busy_q;
	logic             done_q;

	logic [RW-1:0]    rem_sh;
	logic [RW-1:0]    trial;
	logic [RW:0]      diff;
	logic             ge;

	always_comb begin
		if (mode_q) begin
			rem_sh = {rem_q[RW-3:0], op_q[OP_W-1 -: 2]};
			trial  = {res_q[RW-3:0], 2'b01};
		end else begin
			rem_sh = {rem_q[RW-2:0], op_q[OP_W-1]};
			trial  = {{(RW-DVS_W){1'b0}}, dvs_q};
		end
		diff = {1'b0, rem_sh} - {1'b0, trial};
		ge   = ~diff[RW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
			mode_q  <= 1'b0;
		end else begin
			done_q <= busy_q && (steps_q == SC_W'(1));
			if (ctl.start) begin
				busy_q  <= 1'b1;
				mode_q  <= ctl.sqrt_mode;
				steps_q <= ctl.sqrt_mode ? SC_W'(wvad_pkg::SQ_W / 2) : SC_W'(DIV_W);
			end else if (busy_q) begin
				steps_q <= steps_q - SC_W'(1);
				if (steps_q == SC_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			// left-align the operand so its top bits feed the remainder first
			op_q  <= ctl.sqrt_mode ? (opnd << (OP_W - wvad_pkg::SQ_W)) : (opnd << (OP_W - DIV_W));
			dvs_q <= divisor;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			op_q  <= mode_q ? {op_q[OP_W-3:0], 2'b00} : {op_q[OP_W-2:0], 1'b0};
			rem_q <= ge ? diff[RW-1:0] : rem_sh;
			res_q <= {res_q[OP_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = res_q;

endmodule

@@ sv/windowed_velocity_average_distance_top.sv @@
// Top level: window store, query sequencer, shared multiplier and divide/root unit.
//
//  channel | direction | handshake              | contents
//  s_*     | in        | s_tvalid / s_tready    | sample or query item, tuser = opcode
//  m_*     | out       | m_tvalid / m_tready    | means and distance, tuser = window empty
//  cfg_*   | in        | cfg_valid / cfg_ready  | window length (7 bits)
//
// A sample is stored without leaving the idle state. A query keeps s_tready low while the
// sequencer squares dx and dy, runs the 18-step root, reads the window one entry per cycle
// newest first, runs the two 23-step divides in the shared unit (skipped for an empty window)
// and loads the output register, which holds a finished result until m_tready; a further
// query waits while that register is still full.
// Reset clears position, count, slot and length (to 8); window entries start unwritten.
module windowed_velocity_average_distance_top #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x, pos_y, lin_vel, ang_vel, goal_x, goal_y
	input  logic [wvad_pkg::S_TDATA_W-1:0]   s_tdata,
	// opcode
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// distance, mean_lin_vel, mean_ang_vel, zero fill
	output logic [wvad_pkg::M_TDATA_W-1:0]   m_tdata,
	// window_empty
	output logic                             m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wvad_pkg::WLEN_W-1:0]      cfg_data
);

	localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW   = $clog2(WINDOW_MAX + 1);
	localparam int SUMW = wvad_pkg::VEL_W + CW;
	localparam int OP_W = (SUMW > wvad_pkg::SQ_W) ? SUMW : wvad_pkg::SQ_W;
	localparam int VW   = wvad_pkg::VEL_W;
	localparam int DFW  = wvad_pkg::DIFF_W;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL_X = 8'b0000_0010,
		ST_MUL_Y = 8'b0000_0100,
		ST_ROOT  = 8'b0000_1000,
		ST_WALK  = 8'b0001_0000,
		ST_DIV_L = 8'b0010_0000,
		ST_DIV_A = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [wvad_pkg::WLEN_W-1:0] wlen_q;
	logic [wvad_pkg::POS_W-1:0]  last_x_q, last_y_q;
	logic [AW-1:0]               newest_q;
	logic [CW-1:0]               count_q;

	logic signed [DFW-1:0]       dx_q, dy_q;
	logic [wvad_pkg::SQ_W-1:0]   sq_q;
	logic [AW-1:0]               addr_q;
	logic [CW-1:0]               left_q;
	logic                        rd_s1;
	logic signed [SUMW-1:0]      sum_lin_q, sum_ang_q;
	logic                        go_q;

	logic [wvad_pkg::DIST_W-1:0] dist_q;
	logic [VW-1:0]               mean_lin_q, mean_ang_q;

	logic                        out_vld_q;
	logic [wvad_pkg::DIST_W-1:0] out_dist_q;
	logic [VW-1:0]               out_lin_q, out_ang_q;
	logic                        out_empty_q;

	logic                        in_xfer, smp_xfer, qry_xfer, out_free;
	logic [CW-1:0]               len_eff;
	logic [CW:0]                 count_inc;
	logic [AW-1:0]               newest_nxt;
	logic [AW-1:0]               addr_prev;

	logic signed [DFW-1:0]       mul_op;
	logic signed [2*DFW-1:0]     mul_prod;
	logic [wvad_pkg::SQ_W-1:0]   sq_add;

	logic [2*VW-1:0]             mem_rdata;
	logic [VW-1:0]               rd_lin, rd_ang;

	wvad_pkg::unit_ctl_t         u_ctl;
	wvad_pkg::unit_sts_t         u_sts;
	logic [OP_W-1:0]             u_opnd;
	logic [OP_W-1:0]             u_res;
	logic                        sum_neg;
	logic signed [SUMW-1:0]      sum_sel;
	logic [SUMW-1:0]             sum_mag;
	logic [VW-1:0]               quo;
	logic [VW-1:0]               mean_val;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign smp_xfer  = in_xfer && (s_tuser == wvad_pkg::OP_SAMPLE);
	assign qry_xfer  = in_xfer && (s_tuser == wvad_pkg::OP_QUERY);
	assign out_free  = !out_vld_q || m_tready;

	// Length above capacity acts as capacity
	assign len_eff    = (32'(wlen_q) > 32'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(wlen_q);
	assign count_inc  = {1'b0, count_q} + (CW+1)'(1);
	assign newest_nxt = (newest_q == AW'(WINDOW_MAX - 1)) ? '0 : newest_q + AW'(1);
	assign addr_prev  = (addr_q == '0) ? AW'(WINDOW_MAX - 1) : addr_q - AW'(1);

	assign mul_op   = (state_q == ST_MUL_X) ? dx_q : dy_q;
	assign mul_prod = mul_op * mul_op;
	assign sq_add   = {{(wvad_pkg::SQ_W-2*DFW){1'b0}}, mul_prod};

	assign rd_lin = mem_rdata[VW-1:0];
	assign rd_ang = mem_rdata[2*VW-1:VW];

	wvad_win_mem #(
		.DEPTH (WINDOW_MAX),
		.AW    (AW),
		.DW    (2*VW)
	) u_mem (
		.clk   (clk),
		.we    (smp_xfer),
		.waddr (newest_nxt),
		.wdata ({s_tdata[63:48], s_tdata[47:32]}),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// Magnitude and sign of the sum being divided
	always_comb begin
		sum_sel = (state_q == ST_DIV_A) ? sum_ang_q : sum_lin_q;
		sum_neg = sum_sel[SUMW-1];
		sum_mag = sum_neg ? SUMW'(-sum_sel) : SUMW'(sum_sel);
		quo      = u_res[VW-1:0];
		mean_val = sum_neg ? VW'(-quo) : quo;
	end

	assign u_ctl.start     = go_q;
	assign u_ctl.sqrt_mode = (state_q == ST_ROOT);
	assign u_opnd = (state_q == ST_ROOT) ? OP_W'(sq_q) : OP_W'(sum_mag);

	wvad_divsqrt #(
		.DIV_W (SUMW),
		.DVS_W (CW)
	) u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (u_ctl),
		.opnd    (u_opnd),
		.divisor (count_q),
		.sts     (u_sts),
		.res     (u_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wlen_q    <= wvad_pkg::WLEN_RST;
			last_x_q  <= '0;
			last_y_q  <= '0;
			newest_q  <= '0;
			count_q   <= '0;
			go_q      <= 1'b0;
			rd_s1     <= 1'b0;
			left_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// start the shared unit for the root and for each divide
			go_q <= (state_q == ST_MUL_Y)
				|| ((state_q == ST_WALK) && (left_q == '0) && !rd_s1 && (count_q != '0))
				|| ((state_q == ST_DIV_L) && u_sts.done);
			out_vld_q <= ((state_q == ST_DONE) && out_free) || (out_vld_q && !m_tready);
			if (cfg_valid && cfg_ready) begin
				wlen_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (smp_xfer) begin
						last_x_q <= s_tdata[15:0];
						last_y_q <= s_tdata[31:16];
						newest_q <= newest_nxt;
						count_q  <= (count_inc > {1'b0, len_eff}) ? len_eff : count_inc[CW-1:0];
					end else if (qry_xfer) begin
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: begin
					state_q <= ST_MUL_Y;
				end
				ST_MUL_Y: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (u_sts.done) begin
						state_q <= ST_WALK;
						left_q  <= count_q;
						rd_s1   <= 1'b0;
					end
				end
				ST_WALK: begin
					// issue one read per cycle, newest entry first
					rd_s1 <= (left_q != '0);
					if (left_q != '0) begin
						left_q <= left_q - CW'(1);
					end else if (!rd_s1) begin
						if (count_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV_L;
						end
					end
				end
				ST_DIV_L: begin
					if (u_sts.done) begin
						state_q <= ST_DIV_A;
					end
				end
				ST_DIV_A: begin
					if (u_sts.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dx_q <= {s_tdata[79], s_tdata[79:64]} - {last_x_q[15], last_x_q};
				dy_q <= {s_tdata[95], s_tdata[95:80]} - {last_y_q[15], last_y_q};
			end
			ST_MUL_X: begin
				sq_q <= sq_add;
			end
			ST_MUL_Y: begin
				sq_q <= sq_q + sq_add;
			end
			ST_ROOT: begin
				dist_q     <= u_res[wvad_pkg::DIST_W-1:0];
				addr_q     <= newest_q;
				sum_lin_q  <= '0;
				sum_ang_q  <= '0;
				mean_lin_q <= '0;
				mean_ang_q <= '0;
			end
			ST_WALK: begin
				if (left_q != '0) begin
					addr_q <= addr_prev;
				end
				if (rd_s1) begin
					sum_lin_q <= sum_lin_q + {{(SUMW-VW){rd_lin[VW-1]}}, rd_lin};
					sum_ang_q <= sum_ang_q + {{(SUMW-VW){rd_ang[VW-1]}}, rd_ang};
				end
			end
			ST_DIV_L: begin
				if (u_sts.done) begin
					mean_lin_q <= mean_val;
				end
			end
			ST_DIV_A: begin
				if (u_sts.done) begin
					mean_ang_q <= mean_val;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_dist_q  <= dist_q;
					out_lin_q   <= mean_lin_q;
					out_ang_q   <= mean_ang_q;
					out_empty_q <= (count_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_empty_q;
	assign m_tdata  = {{(wvad_pkg::M_TDATA_W - wvad_pkg::DIST_W - 2*VW){1'b0}},
		out_ang_q, out_lin_q, out_dist_q};

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(WINDOW_MAX))
		else $error("stored count exceeds window capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[48:17] == '0))
		else $error("empty window result carries non-zero means");

	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		u_sts.done |-> (state_q == ST_ROOT || state_q == ST_DIV_L || state_q == ST_DIV_A))
		else $error("shared unit finished outside a root or divide step");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == wvad_pkg::OP_QUERY) |=> !s_tready)
		else $error("input still ready after a query transfer");

endmodule

@@ dv/windowed_velocity_average_distance_checker.sv @@
// Checker for the windowed velocity average and distance block: predicts and compares reports.
`timescale 1ns / 1ps
module windowed_velocity_average_distance_checker #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// pos_x, pos_y, lin_vel, ang_vel, goal_x, goal_y
	input  logic [wvad_pkg::S_TDATA_W-1:0]   s_tdata,
	// opcode
	input  logic                             s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// distance, mean_lin_vel, mean_ang_vel, zero fill
	input  logic [wvad_pkg::M_TDATA_W-1:0]   m_tdata,
	// window_empty
	input  logic                             m_tuser,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [wvad_pkg::WLEN_W-1:0]      cfg_data,
	output int                               fail_count,
	output int                               reports_due
);

	typedef struct {
		logic [wvad_pkg::DIST_W-1:0] distance;
		logic signed [15:0]          mean_lin;
		logic signed [15:0]          mean_ang;
		logic                        empty;
	} velocity_report_t;

	velocity_report_t pending_reports[$];
	velocity_report_t want;

	// Predicted block state
	logic [wvad_pkg::WLEN_W-1:0] window_len;
	logic signed [15:0]          held_pos_x;
	logic signed [15:0]          held_pos_y;
	logic signed [15:0]          lin_hist [DEPTH];
	logic signed [15:0]          ang_hist [DEPTH];
	int                          newest;
	int                          stored;

	int     fails;
	int     cap;
	int     dx;
	int     dy;
	int     slot;
	longint sq;
	longint root;
	longint trial;
	longint sum_lin;
	longint sum_ang;

	task automatic check_field(input string field, input longint exp_val, input longint act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len = wvad_pkg::WLEN_RST;
			held_pos_x = '0;
			held_pos_y = '0;
			newest     = 0;
			stored     = 0;
			fails      = 0;
			pending_reports.delete();
			fail_count  <= 0;
			reports_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				window_len = cfg_data;

			if (s_tvalid && s_tready) begin
				if (s_tuser == wvad_pkg::OP_SAMPLE) begin
					cap = (window_len > DEPTH) ? DEPTH : int'(window_len);
					held_pos_x = s_tdata[15:0];
					held_pos_y = s_tdata[31:16];
					newest = (newest + 1) % DEPTH;
					lin_hist[newest] = s_tdata[47:32];
					ang_hist[newest] = s_tdata[63:48];
					stored = stored + 1;
					// trim to the current length only when a sample arrives
					if (stored > cap)
						stored = cap;
				end else begin
					dx = int'($signed(s_tdata[79:64])) - int'(held_pos_x);
					dy = int'($signed(s_tdata[95:80])) - int'(held_pos_y);
					sq = longint'(dx) * dx + longint'(dy) * dy;
					// floor of the square root, one result bit at a time
					root = 0;
					for (int b = wvad_pkg::DIST_W - 1; b >= 0; b--) begin
						trial = root | (longint'(1) << b);
						if (trial * trial <= sq)
							root = trial;
					end
					sum_lin = 0;
					sum_ang = 0;
					for (int k = 0; k < stored; k++) begin
						slot = (newest - k + DEPTH) % DEPTH;
						sum_lin += lin_hist[slot];
						sum_ang += ang_hist[slot];
					end
					want.distance = root[wvad_pkg::DIST_W-1:0];
					want.empty    = (stored == 0);
					want.mean_lin = (stored == 0) ? 16'sd0 : 16'(sum_lin / stored);
					want.mean_ang = (stored == 0) ? 16'sd0 : 16'(sum_ang / stored);
					pending_reports.push_back(want);
				end
			end

			if (m_tvalid && m_tready) begin
				if (pending_reports.size() == 0) begin
					$error("report transfer with no query outstanding");
					fails++;
				end else begin
					want = pending_reports.pop_front();
					check_field("distance", want.distance, m_tdata[16:0]);
					check_field("mean_lin_vel", want.mean_lin, $signed(m_tdata[32:17]));
					check_field("mean_ang_vel", want.mean_ang, $signed(m_tdata[48:33]));
					check_field("window_empty", want.empty, m_tuser);
				end
			end

			fail_count  <= fails;
			reports_due <= pending_reports.size();
		end
	end

endmodule

@@ dv/windowed_velocity_average_distance_top_tb.sv @@
// Testbench top: clock, reset, telemetry stimulus, window length writes and verdict.
`timescale 1ns / 1ps
module windowed_velocity_average_distance_top_tb;

	localparam int WINDOW_DEPTH  = 64;
	localparam int SAMPLE_SETTLE = 8;
	localparam int TAIL_CYCLES   = 200;
	localparam int QUIET_LIMIT   = 4000;
	localparam int ITEMS_PER_LEN = 108;

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [wvad_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
	logic                             s_tuser   = wvad_pkg::OP_SAMPLE;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [wvad_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                             m_tuser;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [wvad_pkg::WLEN_W-1:0]      cfg_data  = '0;

	int fail_count;
	int reports_due;
	int sender_idle_pct   = 22;
	int receiver_idle_pct = 72;

	windowed_velocity_average_distance_top #(
		.WINDOW_MAX(WINDOW_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	windowed_velocity_average_distance_checker #(
		.DEPTH(WINDOW_DEPTH)
	) report_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.reports_due (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Q8.8 value biased towards the range limits
	function automatic logic [15:0] pick_q88();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Leaves s_tvalid high after the transfer so back-to-back items need no gap
	task automatic send_telemetry(input logic op, input logic [15:0] pos_x,
			input logic [15:0] pos_y, input logic [15:0] lin_vel, input logic [15:0] ang_vel,
			input logic [15:0] goal_x, input logic [15:0] goal_y);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {goal_y, goal_x, ang_vel, lin_vel, pos_y, pos_x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_until_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
		// a trailing sample may still be in flight
		repeat (SAMPLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_window_length(input logic [wvad_pkg::WLEN_W-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[windowed_velocity_average_distance_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [wvad_pkg::WLEN_W-1:0] lengths [6];
		lengths = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd5, 7'd5};
		lengths[4] = 7'($urandom_range(63, 2));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty window straight after reset, goal at the far corners
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			16'h8000, 16'h8000);
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			16'h7FFF, 16'h7FFF);
		// position and velocities at the extremes, goal across the whole range
		send_telemetry(wvad_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
			pick_q88(), pick_q88());
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			16'h8000, 16'h8000);
		send_telemetry(wvad_pkg::OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
			pick_q88(), pick_q88());
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			16'h7FFF, 16'h8000);
		// overfill the reset-length window; negative sums exercise truncation toward zero
		for (int k = 0; k < 10; k++)
			send_telemetry(wvad_pkg::OP_SAMPLE, pick_q88(), pick_q88(), 16'(-3 * k - 1),
				16'(5 * k + 1), pick_q88(), pick_q88());
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			pick_q88(), pick_q88());

		// shorter length: the next query still averages all stored entries
		wait_until_idle();
		write_window_length(7'd3);
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			pick_q88(), pick_q88());
		send_telemetry(wvad_pkg::OP_SAMPLE, pick_q88(), pick_q88(), 16'hFFF9, 16'h0007,
			pick_q88(), pick_q88());
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			pick_q88(), pick_q88());

		// zero length keeps nothing; goal on the held position gives zero distance
		wait_until_idle();
		write_window_length(7'd0);
		send_telemetry(wvad_pkg::OP_SAMPLE, 16'h0064, 16'hFF38, pick_q88(), pick_q88(),
			pick_q88(), pick_q88());
		send_telemetry(wvad_pkg::OP_QUERY, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
			16'h0064, 16'hFF38);

		for (int p = 0; p < 6; p++) begin
			wait_until_idle();
			write_window_length(lengths[p]);
			sender_idle_pct   = (p < 2) ? 22 : (p < 4) ? 72 : 0;
			receiver_idle_pct = (p < 2) ? 72 : (p < 4) ? 22 : 0;
			repeat (ITEMS_PER_LEN)
				send_telemetry(($urandom_range(99) < 30) ? wvad_pkg::OP_QUERY
					: wvad_pkg::OP_SAMPLE, pick_q88(), pick_q88(), pick_q88(), pick_q88(),
					pick_q88(), pick_q88());
		end

		wait_until_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[windowed_velocity_average_distance_top] OK");
		else
			$display("[windowed_velocity_average_distance_top] ERROR");
		$finish;
	end

endmodule
